// ----- rtl/core/mcsr_pkg.sv -----
// ----------------------------------------------------------------------------
// mcsr_pkg
// Shared types and constants of the machine-mode CSR unit: CSR addresses,
// funct3 codes and the request and response payloads.
// ----------------------------------------------------------------------------
package mcsr_pkg;

	// csr addresses
	localparam logic [11:0] ADDR_MSTATUS = 12'h300;
	localparam logic [11:0] ADDR_MRET    = 12'h302;
	localparam logic [11:0] ADDR_MIE     = 12'h304;
	localparam logic [11:0] ADDR_MTVEC   = 12'h305;
	localparam logic [11:0] ADDR_MEPC    = 12'h341;
	localparam logic [11:0] ADDR_MCAUSE  = 12'h342;
	localparam logic [11:0] ADDR_MIP     = 12'h344;
	localparam logic [11:0] ADDR_MCYCLE  = 12'hb00;
	localparam logic [11:0] ADDR_MCYCLEH = 12'hb80;

	// funct3 codes
	localparam logic [2:0] ACT_SYSTEM = 3'd0;
	localparam logic [2:0] ACT_RW     = 3'd1;
	localparam logic [2:0] ACT_RS     = 3'd2;
	localparam logic [2:0] ACT_RC     = 3'd3;
	localparam logic [2:0] ACT_NONE   = 3'd4;
	localparam logic [2:0] ACT_RWI    = 3'd5;
	localparam logic [2:0] ACT_RSI    = 3'd6;
	localparam logic [2:0] ACT_RCI    = 3'd7;

	// low two bits of funct3 select the operation kind
	localparam logic [1:0] KIND_WRITE = 2'd1;
	localparam logic [1:0] KIND_SET   = 2'd2;
	localparam logic [1:0] KIND_CLEAR = 2'd3;

	// mcause bits touched by a trap
	localparam logic [31:0] CAUSE_INT_MASK = 32'h7fff_ffff;
	localparam logic [31:0] CAUSE_ILLEGAL  = 32'h0000_0004;

	typedef struct packed {
		logic        is_csr;
		logic [2:0]  action;
		logic [11:0] csr_address;
		logic [4:0]  dest_index;
		logic [4:0]  source_index;
		logic [31:0] source_value;
		logic [31:0] current_pc;
		logic        illegal_flag;
		logic        misaligned_flag;
	} mcsr_req_t;

	typedef struct packed {
		logic        read_valid;
		logic [31:0] read_data;
		logic        redirect;
		logic [31:0] redirect_pc;
	} mcsr_rsp_t;

endpackage

// ----- rtl/core/mcsr_req_if.sv -----
// ----------------------------------------------------------------------------
// mcsr_req_if
// Valid/ready channel carrying one CSR unit request per handshake.
// ----------------------------------------------------------------------------
interface mcsr_req_if
	import mcsr_pkg::*;
;
	logic      valid;
	logic      ready;
	mcsr_req_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

// ----- rtl/core/mcsr_rsp_if.sv -----
// ----------------------------------------------------------------------------
// mcsr_rsp_if
// Valid/ready channel carrying one CSR unit response per handshake.
// ----------------------------------------------------------------------------
interface mcsr_rsp_if
	import mcsr_pkg::*;
;
	logic      valid;
	logic      ready;
	mcsr_rsp_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

// ----- rtl/core/mcsr_file.sv -----
// ----------------------------------------------------------------------------
// mcsr_file
// Machine-mode CSR storage with the cycle counter, the CSR access logic,
// trap entry and mret. State advances once per request when step is high.
// ----------------------------------------------------------------------------
module mcsr_file
	import mcsr_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      step,
	input  mcsr_req_t item,
	output mcsr_rsp_t result
);

	logic [31:0] status_q, ie_q, ip_q, cause_q, epc_q, tvec_q;
	logic [63:0] cycle_q;

	logic [31:0] old_val, operand, new_val;
	logic        access, do_write;
	logic [31:0] status_mid, ie_mid, ip_mid, cause_mid, epc_mid, tvec_mid;
	logic        trap_ill, trap_mis, is_mret;
	logic [31:0] status_d, ie_d, ip_d, cause_d, epc_d, tvec_d;

	// read mux, old value before any write
	always_comb begin
		case (item.csr_address)
			ADDR_MSTATUS: old_val = status_q;
			ADDR_MIE:     old_val = ie_q;
			ADDR_MTVEC:   old_val = tvec_q;
			ADDR_MEPC:    old_val = epc_q;
			ADDR_MCAUSE:  old_val = cause_q;
			ADDR_MIP:     old_val = ip_q;
			ADDR_MCYCLE:  old_val = cycle_q[31:0];
			ADDR_MCYCLEH: old_val = cycle_q[63:32];
			default:      old_val = '0;
		endcase
	end

	// access decode and new value
	always_comb begin
		access = item.is_csr && (item.action != ACT_SYSTEM) && (item.action != ACT_NONE);
		operand = item.action[2] ? {27'd0, item.source_index} : item.source_value;
		case (item.action[1:0])
			KIND_WRITE: new_val = operand;
			KIND_SET:   new_val = old_val | operand;
			default:    new_val = old_val & ~operand;
		endcase
		do_write = access && ((item.action[1:0] == KIND_WRITE) || (item.source_index != 5'd0));
	end

	// csr write, read-only and unmapped addresses fall through untouched
	always_comb begin
		status_mid = (do_write && item.csr_address == ADDR_MSTATUS) ? new_val : status_q;
		ie_mid     = (do_write && item.csr_address == ADDR_MIE)     ? new_val : ie_q;
		tvec_mid   = (do_write && item.csr_address == ADDR_MTVEC)   ? new_val : tvec_q;
		epc_mid    = (do_write && item.csr_address == ADDR_MEPC)    ? new_val : epc_q;
		cause_mid  = (do_write && item.csr_address == ADDR_MCAUSE)  ? new_val : cause_q;
		ip_mid     = (do_write && item.csr_address == ADDR_MIP)     ? new_val : ip_q;
	end

	// trap entry and mret, illegal first, then misaligned, then mret
	always_comb begin
		trap_ill = item.illegal_flag && (epc_mid == 32'd0);
		trap_mis = !trap_ill && item.misaligned_flag && (epc_mid == 32'd0);
		is_mret  = !trap_ill && !trap_mis && item.is_csr && (item.action == ACT_SYSTEM)
			&& (item.csr_address == ADDR_MRET);

		status_d = status_mid;
		ie_d     = ie_mid;
		ip_d     = ip_mid;
		cause_d  = cause_mid;
		epc_d    = epc_mid;
		tvec_d   = tvec_mid;
		if (trap_ill) begin
			epc_d   = item.current_pc;
			cause_d = (cause_mid & CAUSE_INT_MASK) | CAUSE_ILLEGAL;
		end else if (trap_mis) begin
			epc_d   = item.current_pc;
			cause_d = cause_mid & CAUSE_INT_MASK;
		end else if (is_mret) begin
			status_d = '0;
			cause_d  = '0;
			tvec_d   = '0;
			ip_d     = '0;
			ie_d     = '0;
		end
	end

	// response
	always_comb begin
		result.read_valid  = access && (item.dest_index != 5'd0);
		result.read_data   = result.read_valid ? old_val : '0;
		result.redirect    = trap_ill || trap_mis || is_mret;
		result.redirect_pc = (trap_ill || trap_mis) ? tvec_mid : (is_mret ? epc_mid : '0);
	end

	// state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			status_q <= '0;
			ie_q     <= '0;
			ip_q     <= '0;
			cause_q  <= '0;
			epc_q    <= '0;
			tvec_q   <= '0;
			cycle_q  <= '0;
		end else if (step) begin
			status_q <= status_d;
			ie_q     <= ie_d;
			ip_q     <= ip_d;
			cause_q  <= cause_d;
			epc_q    <= epc_d;
			tvec_q   <= tvec_d;
			cycle_q  <= cycle_q + 64'd1;
		end
	end

endmodule

// ----- rtl/core/machine_mode_csr_unit_top.sv -----
// ----------------------------------------------------------------------------
// machine_mode_csr_unit_top
// Machine-mode CSR unit: one request per instruction cycle, one response each.
// ----------------------------------------------------------------------------
// Usage:
//   req carries one instruction cycle per request: CSR access fields, rs1
//   value, pc and the illegal and misaligned trap flags. Every accepted
//   request advances the 64-bit mcycle counter by one.
//   rsp carries exactly one response per request, in order: read_valid and
//   read_data (old CSR value, zero if unmapped) plus redirect and
//   redirect_pc (mtvec on a trap, mepc on mret).
// Pipeline:
//   a request accepted on req is held in the input register; its response
//   is loaded into the output register once that register is free and is
//   offered on rsp from there. One request per cycle is sustained while
//   rsp.ready stays high; the CSR update is a single pass between the two
//   registers.
// Reset:
//   arst_n clears all CSRs, the counter and both valid flags at once.
// Stall:
//   while rsp.ready is low the held response stays put; the input register
//   still takes one more request, after which req.ready drops until the
//   output register is freed.
// ----------------------------------------------------------------------------
module machine_mode_csr_unit_top
	import mcsr_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	mcsr_req_if.sink   req,
	mcsr_rsp_if.source rsp
);

	mcsr_req_t req_s1;
	logic      valid_s1;
	mcsr_rsp_t rsp_q;
	logic      rsp_valid_q;
	mcsr_rsp_t result;
	logic      out_free, advance;

	// handshake control
	assign out_free  = !rsp_valid_q || rsp.ready;
	assign advance   = valid_s1 && out_free;
	assign req.ready = !valid_s1 || advance;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req.valid && req.ready) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			req_s1 <= req.payload;
		end
	end

	// csr state and single-pass update
	mcsr_file u_file (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (advance),
		.item   (req_s1),
		.result (result)
	);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (advance) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			rsp_q <= result;
		end
	end

	assign rsp.valid   = rsp_valid_q;
	assign rsp.payload = rsp_q;

endmodule
